### rtl/multichannel_frame_deframer_core_macros.svh
// Assertion macros for the multichannel frame deframer.
`ifndef MULTICHANNEL_FRAME_DEFRAMER_CORE_MACROS_SVH
`define MULTICHANNEL_FRAME_DEFRAMER_CORE_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define MFD_ASSERT(lbl, cond, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) else $error(msg);

// Check that a consequence holds in the cycle after its trigger.
`define MFD_ASSERT_NEXT(lbl, trig, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (trig) |=> (cons)) \
        else $error(msg);

`endif

### rtl/mfd_pkg.sv
// Package with types, constants and codes of the multichannel frame deframer.
package mfd_pkg;

    localparam int NUM_CHANNELS = 16;
    localparam int CH_AW        = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int HEADER_BYTES = 16;
    localparam int HDR_CW       = $clog2(HEADER_BYTES);

    localparam int HDR_VERSION_OFS = 4;
    localparam int HDR_TYPE_OFS    = 5;
    localparam int HDR_SEQ_OFS     = 8;
    localparam int HDR_LEN_OFS     = 12;

    localparam int OUT_DEPTH = 3;
    localparam int OUT_PW    = $clog2(OUT_DEPTH);
    localparam int OUT_LW    = $clog2(OUT_DEPTH + 1);

    localparam logic [1:0] CFG_FRAME_MAGIC      = 2'd0;
    localparam logic [1:0] CFG_PROTOCOL_VERSION = 2'd1;
    localparam logic [1:0] CFG_MAX_PAYLOAD_LEN  = 2'd2;

    localparam logic [31:0] RST_FRAME_MAGIC      = 32'd0;
    localparam logic [7:0]  RST_PROTOCOL_VERSION = 8'd1;
    localparam logic [31:0] RST_MAX_PAYLOAD_LEN  = 32'd1048576;

    typedef enum logic [1:0] {
        PH_HEADER  = 2'd0,
        PH_PAYLOAD = 2'd1,
        PH_DISCARD = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        EV_PAYLOAD = 2'd0,
        EV_EMPTY   = 2'd1,
        EV_BAD_HDR = 2'd2,
        EV_ABORT   = 2'd3
    } event_t;

    typedef struct packed {
        phase_t              phase;
        logic [HDR_CW-1:0]   count;
        logic [31:0]         magic;
        logic [7:0]          version;
        logic [7:0]          mtype;
        logic [31:0]         seq;
        logic [31:0]         len;
    } chan_state_t;

    typedef struct packed {
        logic [3:0]  channel;
        event_t      ev;
        logic [7:0]  mtype;
        logic [31:0] seq;
        logic [7:0]  pbyte;
        logic        last;
    } result_t;

    typedef struct packed {
        logic [OUT_LW-1:0] level;
        logic              push;
        logic              pop;
    } fifo_status_t;

endpackage

### rtl/mfd_ram.sv
// Generic simple dual-port RAM with registered read.
module mfd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                    aclk,
    input  logic                                    we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic                                    re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem_reg[raddr];
        end
    end

endmodule

### rtl/mfd_out_fifo.sv
// Result queue between the channel update stage and the master port.
module mfd_out_fifo (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    push,
    input  mfd_pkg::result_t        push_data,
    output logic                    out_valid,
    input  logic                    out_ready,
    output mfd_pkg::result_t        out_data,
    output mfd_pkg::fifo_status_t   status
);
    import mfd_pkg::*;

    result_t           entry_reg [OUT_DEPTH];
    logic [OUT_PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [OUT_PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [OUT_LW-1:0] level_reg, level_next;
    logic              pop;

    assign out_valid = (level_reg != '0);
    assign out_data  = entry_reg[rd_ptr_reg];
    assign pop       = out_valid && out_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        level_next  = level_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == OUT_PW'(OUT_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == OUT_PW'(OUT_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            level_next = level_reg + 1'b1;
        end else if (pop && !push) begin
            level_next = level_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign status = '{level: level_reg, push: push, pop: pop};

endmodule

### rtl/multichannel_frame_deframer_core.sv
// Top level of the multichannel length-prefixed frame deframer.
//
//  Port group   Dir  Beat content
//  s_*          in   stream byte or clear command for one channel
//  m_*          out  payload byte, empty frame, bad header or abort event
//  cfg_*        in   register write (magic, version, payload length limit)
//
//  One beat a cycle in and out while the result queue has room and m_tready is high;
//  the channel state memory is read first, then the state is updated, written back and queued.
//  Back-to-back beats on one channel see the written state through a bypass.
//  A three-entry result queue lets input continue while results wait.
//  Reset is synchronous; per-channel valid bits make all channels hunt headers.
`include "multichannel_frame_deframer_core_macros.svh"

module multichannel_frame_deframer_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,    // channel[3:0], data_byte[11:4], zero[15:12]
    input  logic        s_tuser,    // kind
    input  logic        s_tlast,    // chunk_end
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,    // out_channel[3:0], msg_type[11:4], seq_id[43:12],
                                    // payload_byte[51:44], zero[55:52]
    output logic [1:0]  m_tuser,    // event_res
    output logic        m_tlast,    // frame_last
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_wdata
);
    import mfd_pkg::*;

    logic [31:0] cfg_magic_reg;
    logic [7:0]  cfg_version_reg;
    logic [31:0] cfg_max_len_reg;

    logic [3:0]       in_channel;
    logic [CH_AW-1:0] in_addr;
    logic             in_ok;
    logic             accept;

    logic             s1_valid_reg;
    logic             s1_kind_reg;
    logic             s1_cend_reg;
    logic [7:0]       s1_byte_reg;
    logic [3:0]       s1_chan_reg;
    logic [CH_AW-1:0] s1_addr_reg;

    logic             fwd_hit_reg;
    chan_state_t      fwd_data_reg;
    logic [NUM_CHANNELS-1:0] valid_reg;

    logic [$bits(chan_state_t)-1:0] rd_data;
    chan_state_t st_cur, st_next;

    logic [31:0] len_shift;
    logic [31:0] rem_dec;
    logic        hdr_last;
    logic        hdr_bad;

    result_t      res;
    logic         res_valid;
    logic         push;
    result_t      out_res;
    fifo_status_t fifo_st;
    logic [OUT_LW:0] space_used;

    // Input side
    assign in_channel = s_tdata[3:0];
    assign in_addr    = CH_AW'(in_channel);
    assign in_ok      = (32'(in_channel) < 32'(NUM_CHANNELS));
    assign space_used = (OUT_LW + 1)'(fifo_st.level) + (OUT_LW + 1)'(s1_valid_reg);
    assign s_tready   = aresetn && (space_used < (OUT_LW + 1)'(OUT_DEPTH));
    assign accept     = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_magic_reg   <= RST_FRAME_MAGIC;
            cfg_version_reg <= RST_PROTOCOL_VERSION;
            cfg_max_len_reg <= RST_MAX_PAYLOAD_LEN;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_FRAME_MAGIC:      cfg_magic_reg   <= cfg_wdata;
                CFG_PROTOCOL_VERSION: cfg_version_reg <= cfg_wdata[7:0];
                CFG_MAX_PAYLOAD_LEN:  cfg_max_len_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    mfd_ram #(
        .WIDTH($bits(chan_state_t)),
        .DEPTH(NUM_CHANNELS)
    ) u_state_ram (
        .aclk  (aclk),
        .we    (s1_valid_reg),
        .waddr (s1_addr_reg),
        .wdata (st_next),
        .re    (accept),
        .raddr (in_addr),
        .rdata (rd_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            fwd_hit_reg  <= 1'b0;
            valid_reg    <= '0;
        end else begin
            s1_valid_reg <= accept && in_ok;
            fwd_hit_reg  <= accept && s1_valid_reg && (in_addr == s1_addr_reg);
            if (s1_valid_reg) begin
                valid_reg[s1_addr_reg] <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_kind_reg <= s_tuser;
            s1_cend_reg <= s_tlast;
            s1_byte_reg <= s_tdata[11:4];
            s1_chan_reg <= in_channel;
            s1_addr_reg <= in_addr;
        end
        fwd_data_reg <= st_next;
    end

    // Channel state with bypass of the write from the previous cycle
    always_comb begin
        if (fwd_hit_reg) begin
            st_cur = fwd_data_reg;
        end else if (valid_reg[s1_addr_reg]) begin
            st_cur = chan_state_t'(rd_data);
        end else begin
            st_cur = '0;
        end
    end

    assign len_shift = {st_cur.len[23:0], s1_byte_reg};
    assign rem_dec   = st_cur.len - 32'd1;
    assign hdr_last  = (st_cur.count == HDR_CW'(HEADER_BYTES - 1));
    assign hdr_bad   = (st_cur.magic != cfg_magic_reg) ||
                       (st_cur.version != cfg_version_reg) ||
                       (len_shift > cfg_max_len_reg);

    // Next channel state
    always_comb begin
        st_next = st_cur;
        if (s1_kind_reg) begin
            st_next = '0;
        end else begin
            unique case (st_cur.phase)
                PH_DISCARD: begin
                    if (s1_cend_reg) begin
                        st_next = '0;
                    end
                end
                PH_PAYLOAD: begin
                    st_next.len = rem_dec;
                    if (rem_dec == '0) begin
                        st_next.phase = PH_HEADER;
                        st_next.count = '0;
                    end
                end
                PH_HEADER: begin
                    if (st_cur.count < HDR_CW'(HDR_VERSION_OFS)) begin
                        st_next.magic = {st_cur.magic[23:0], s1_byte_reg};
                    end else if (st_cur.count == HDR_CW'(HDR_VERSION_OFS)) begin
                        st_next.version = s1_byte_reg;
                    end else if (st_cur.count == HDR_CW'(HDR_TYPE_OFS)) begin
                        st_next.mtype = s1_byte_reg;
                    end else if (st_cur.count >= HDR_CW'(HDR_SEQ_OFS) &&
                                 st_cur.count < HDR_CW'(HDR_LEN_OFS)) begin
                        st_next.seq = {st_cur.seq[23:0], s1_byte_reg};
                    end else if (st_cur.count >= HDR_CW'(HDR_LEN_OFS)) begin
                        st_next.len = len_shift;
                    end
                    st_next.count = st_cur.count + 1'b1;
                    if (hdr_last) begin
                        st_next.count = '0;
                        if (hdr_bad) begin
                            st_next.phase = s1_cend_reg ? PH_HEADER : PH_DISCARD;
                        end else if (len_shift == '0) begin
                            st_next.phase = PH_HEADER;
                        end else begin
                            st_next.phase = PH_PAYLOAD;
                        end
                    end
                end
                default: st_next = st_cur;
            endcase
        end
    end

    // Result of the beat
    always_comb begin
        res_valid   = 1'b0;
        res.channel = s1_chan_reg;
        res.ev      = EV_PAYLOAD;
        res.mtype   = st_cur.mtype;
        res.seq     = st_cur.seq;
        res.pbyte   = '0;
        res.last    = 1'b0;
        if (s1_kind_reg) begin
            if (st_cur.phase == PH_PAYLOAD) begin
                res_valid = 1'b1;
                res.ev    = EV_ABORT;
            end
        end else begin
            unique case (st_cur.phase)
                PH_PAYLOAD: begin
                    res_valid = 1'b1;
                    res.ev    = EV_PAYLOAD;
                    res.pbyte = s1_byte_reg;
                    res.last  = (rem_dec == '0);
                end
                PH_HEADER: begin
                    if (hdr_last) begin
                        if (hdr_bad) begin
                            res_valid = 1'b1;
                            res.ev    = EV_BAD_HDR;
                        end else if (len_shift == '0) begin
                            res_valid = 1'b1;
                            res.ev    = EV_EMPTY;
                        end
                    end
                end
                default: res_valid = 1'b0;
            endcase
        end
    end

    assign push = s1_valid_reg && res_valid;

    mfd_out_fifo u_out_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (res),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_res),
        .status    (fifo_st)
    );

    assign m_tdata = {4'd0, out_res.pbyte, out_res.seq, out_res.mtype, out_res.channel};
    assign m_tuser = out_res.ev;
    assign m_tlast = out_res.last;

    `MFD_ASSERT(a_no_overflow, !(fifo_st.push && !fifo_st.pop && fifo_st.level == OUT_LW'(OUT_DEPTH)), "result queue overflow")
    `MFD_ASSERT(a_ready_room, !s_tready || space_used < (OUT_LW + 1)'(OUT_DEPTH), "ready without queue room")
    `MFD_ASSERT_NEXT(a_stage_fill, accept && in_ok, s1_valid_reg, "accepted beat lost before update")
    `MFD_ASSERT_NEXT(a_bypass_src, fwd_hit_reg == 1'b0 && accept && s1_valid_reg && in_addr == s1_addr_reg, fwd_hit_reg, "missing bypass on same channel")

endmodule

### test/multichannel_frame_deframer_core_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the multichannel frame deframer: framed random traffic vs. a predictor.
module multichannel_frame_deframer_core_tb;
    import mfd_pkg::*;

    localparam int LONG_HOLD    = 200;
    localparam int DRAIN_CYCLES = 10;
    localparam int MAX_PRINTED  = 40;

    typedef struct packed {
        logic       kind;
        logic [3:0] channel;
        logic [7:0] data;
        logic       cend;
    } stream_beat_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;
    logic        s_tuser;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [55:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [31:0] cfg_wdata;

    multichannel_frame_deframer_core DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    logic [31:0] exp_magic;
    logic [7:0]  exp_version;
    logic [31:0] exp_max_len;

    phase_t      ch_phase   [NUM_CHANNELS];
    int unsigned ch_count   [NUM_CHANNELS];
    logic [31:0] ch_magic   [NUM_CHANNELS];
    logic [7:0]  ch_version [NUM_CHANNELS];
    logic [7:0]  ch_type    [NUM_CHANNELS];
    logic [31:0] ch_seq     [NUM_CHANNELS];
    logic [31:0] ch_len     [NUM_CHANNELS];
    logic [31:0] ch_left    [NUM_CHANNELS];

    stream_beat_t beats_to_send[$];
    stream_beat_t chan_todo [NUM_CHANNELS][$];
    result_t      expected_events[$];

    bit beat_taken  = 1'b0;
    bit event_taken = 1'b0;
    int send_idle_pct  = 30;
    int recv_stall_pct = 30;
    int hold_asked = 0;
    int hold_done  = 0;
    int send_wait  = 0;
    int recv_wait  = 0;
    int errors     = 0;
    int beats_in   = 0;
    int events_out = 0;
    int ev_seen [4] = '{0, 0, 0, 0};

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    initial begin
        #2_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic int draw_wait(input int pct);
        return ($urandom_range(0, 99) < pct) ? int'($urandom_range(0, 5)) : 0;
    endfunction

    task automatic report_mismatch(input string what);
        errors++;
        if (errors <= MAX_PRINTED)
            $display("MISMATCH at %0t ns, result %0d: %s", $time, events_out, what);
    endtask

    task automatic compare_field(input string name, input logic [31:0] got,
                                 input logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got 0x%0h, want 0x%0h", name, got, want));
    endtask

    task automatic clear_chan(input int c);
        ch_phase[c]   = PH_HEADER;
        ch_count[c]   = 0;
        ch_magic[c]   = '0;
        ch_version[c] = '0;
        ch_type[c]    = '0;
        ch_seq[c]     = '0;
        ch_len[c]     = '0;
        ch_left[c]    = '0;
    endtask

    task automatic deframe_beat(input stream_beat_t b);
        result_t r;
        int c;
        c = int'(b.channel);
        r = '0;
        r.channel = b.channel;
        r.mtype   = ch_type[c];
        r.seq     = ch_seq[c];
        if (b.kind) begin
            if (ch_phase[c] == PH_PAYLOAD) begin
                r.ev = EV_ABORT;
                expected_events.push_back(r);
            end
            clear_chan(c);
        end else if (ch_phase[c] == PH_DISCARD) begin
            if (b.cend)
                clear_chan(c);
        end else if (ch_phase[c] == PH_PAYLOAD) begin
            ch_left[c] = ch_left[c] - 32'd1;
            r.ev    = EV_PAYLOAD;
            r.pbyte = b.data;
            r.last  = (ch_left[c] == 32'd0);
            expected_events.push_back(r);
            if (r.last) begin
                ch_phase[c] = PH_HEADER;
                ch_count[c] = 0;
            end
        end else begin
            if (ch_count[c] < HDR_VERSION_OFS)
                ch_magic[c] = {ch_magic[c][23:0], b.data};
            else if (ch_count[c] == HDR_VERSION_OFS)
                ch_version[c] = b.data;
            else if (ch_count[c] == HDR_TYPE_OFS)
                ch_type[c] = b.data;
            else if (ch_count[c] >= HDR_SEQ_OFS && ch_count[c] < HDR_LEN_OFS)
                ch_seq[c] = {ch_seq[c][23:0], b.data};
            else if (ch_count[c] >= HDR_LEN_OFS)
                ch_len[c] = {ch_len[c][23:0], b.data};
            ch_count[c]++;
            if (ch_count[c] == HEADER_BYTES) begin
                ch_count[c] = 0;
                r.mtype = ch_type[c];
                r.seq   = ch_seq[c];
                if (ch_magic[c] != exp_magic || ch_version[c] != exp_version ||
                    ch_len[c] > exp_max_len) begin
                    r.ev = EV_BAD_HDR;
                    expected_events.push_back(r);
                    ch_phase[c] = b.cend ? PH_HEADER : PH_DISCARD;
                end else if (ch_len[c] == 32'd0) begin
                    r.ev = EV_EMPTY;
                    expected_events.push_back(r);
                end else begin
                    ch_left[c]  = ch_len[c];
                    ch_phase[c] = PH_PAYLOAD;
                end
            end
        end
    endtask

    // Driver: hold the beat until taken, then idle for a drawn number of cycles.
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= 1'b0;
            s_tlast  <= 1'b0;
        end else if (!(s_tvalid && !beat_taken)) begin
            if (s_tvalid)
                send_wait = draw_wait(send_idle_pct);
            if (send_wait > 0) begin
                send_wait--;
                s_tvalid <= 1'b0;
            end else if (beats_to_send.size() > 0) begin
                s_tvalid <= 1'b1;
                s_tdata  <= {4'b0, beats_to_send[0].data, beats_to_send[0].channel};
                s_tuser  <= beats_to_send[0].kind;
                s_tlast  <= beats_to_send[0].cend;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: may stall after each result; a requested long hold overrides.
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (event_taken)
                recv_wait = draw_wait(recv_stall_pct);
            if (hold_asked != hold_done) begin
                hold_done++;
                recv_wait = LONG_HOLD;
            end
            if (recv_wait > 0) begin
                recv_wait--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        result_t got;
        result_t want;
        beat_taken  = 1'b0;
        event_taken = 1'b0;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                beat_taken = 1'b1;
                beats_in++;
                deframe_beat(beats_to_send.pop_front());
            end
            if (m_tvalid && m_tready) begin
                event_taken = 1'b1;
                events_out++;
                got.channel = m_tdata[3:0];
                got.ev      = event_t'(m_tuser);
                got.mtype   = m_tdata[11:4];
                got.seq     = m_tdata[43:12];
                got.pbyte   = m_tdata[51:44];
                got.last    = m_tlast;
                ev_seen[int'(m_tuser)]++;
                if (expected_events.size() == 0) begin
                    report_mismatch($sformatf("unexpected beat on channel %0d, event %s",
                                              got.channel, got.ev.name()));
                end else begin
                    want = expected_events.pop_front();
                    compare_field("out_channel", got.channel, want.channel);
                    compare_field("event_res", got.ev, want.ev);
                    compare_field("msg_type", got.mtype, want.mtype);
                    compare_field("seq_id", got.seq, want.seq);
                    compare_field("payload_byte", got.pbyte, want.pbyte);
                    compare_field("frame_last", got.last, want.last);
                end
            end
        end
    end

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_FRAME_MAGIC:      exp_magic   = val;
            CFG_PROTOCOL_VERSION: exp_version = val[7:0];
            CFG_MAX_PAYLOAD_LEN:  exp_max_len = val;
            default: ;
        endcase
    endtask

    task automatic set_regs(input logic [31:0] magic, input logic [31:0] ver,
                            input logic [31:0] max_len);
        write_reg(CFG_FRAME_MAGIC, magic);
        write_reg(CFG_PROTOCOL_VERSION, ver);
        write_reg(CFG_MAX_PAYLOAD_LEN, max_len);
    endtask

    task automatic drain();
        while (beats_to_send.size() != 0 || expected_events.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic add_beat(input int ch, input bit kind, input logic [7:0] data,
                            input bit cend);
        stream_beat_t b;
        b.kind    = kind;
        b.channel = 4'(ch);
        b.data    = data;
        b.cend    = cend;
        chan_todo[ch].push_back(b);
    endtask

    task automatic add_header(input int ch, input logic [31:0] magic, input logic [7:0] ver,
                              input logic [7:0] mtype, input logic [31:0] seq,
                              input logic [31:0] len, input bit last_cend);
        logic [127:0] hdr;
        hdr = {magic, ver, mtype, 16'($urandom), seq, len};
        for (int i = 0; i < HEADER_BYTES; i++)
            add_beat(ch, 1'b0, hdr[127 - 8 * i -: 8],
                     (i == HEADER_BYTES - 1) ? last_cend : ($urandom_range(0, 9) == 0));
    endtask

    task automatic add_payload(input int ch, input int unsigned n);
        for (int unsigned i = 0; i < n; i++)
            add_beat(ch, 1'b0, 8'($urandom), $urandom_range(0, 99) < 15);
    endtask

    // One well-formed frame, a broken header, an abort, a cut header or noise.
    task automatic build_sequence(input int ch);
        int pick;
        int unsigned cap;
        int unsigned n;
        logic [31:0] len;
        logic [31:0] magic;
        logic [7:0]  ver;
        bit last_cend;
        longint unsigned room;
        magic = exp_magic;
        ver   = exp_version;
        cap   = (exp_max_len < 12) ? exp_max_len : 12;
        last_cend = $urandom_range(0, 1);
        pick  = $urandom_range(0, 99);
        if (pick < 50) begin
            len = $urandom_range(0, cap);
            add_header(ch, magic, ver, 8'($urandom), $urandom, len, last_cend);
            add_payload(ch, len);
        end else if (pick < 75) begin
            len = $urandom;
            case ($urandom_range(0, 2))
                0: magic = magic ^ (32'd1 << $urandom_range(0, 31));
                1: ver = ver ^ (8'd1 << $urandom_range(0, 7));
                default: begin
                    if (exp_max_len != 32'hFFFF_FFFF) begin
                        room = 64'hFFFF_FFFF - exp_max_len;
                        len = $urandom_range(0, 1) ? exp_max_len + 32'd1 :
                              32'(exp_max_len + 64'd1 + ($urandom % room));
                    end else begin
                        magic = ~magic;
                    end
                end
            endcase
            last_cend = ($urandom_range(0, 9) < 3);
            add_header(ch, magic, ver, 8'($urandom), $urandom, len, last_cend);
            if (!last_cend) begin
                repeat ($urandom_range(0, 4)) add_beat(ch, 1'b0, 8'($urandom), 1'b0);
                add_beat(ch, 1'b0, 8'($urandom), 1'b1);
            end
        end else if (pick < 88) begin
            if (exp_max_len >= 2) begin
                len = $urandom_range(0, 1) ? 32'd2 + ($urandom % (exp_max_len - 32'd1)) :
                      32'($urandom_range(2, cap));
                add_header(ch, magic, ver, 8'($urandom), $urandom, len, last_cend);
                n = (len - 1 > 6) ? 6 : len - 1;
                add_payload(ch, $urandom_range(0, n));
            end
            add_beat(ch, 1'b1, 8'($urandom), $urandom_range(0, 1));
        end else if (pick < 94) begin
            add_payload(ch, $urandom_range(0, HEADER_BYTES - 1));
            add_beat(ch, 1'b1, 8'($urandom), $urandom_range(0, 1));
        end else begin
            add_payload(ch, $urandom_range(1, 20));
            add_beat(ch, 1'b1, 8'($urandom), $urandom_range(0, 1));
        end
    endtask

    // Interleave the per-channel streams in short random bursts.
    task automatic release_traffic();
        int ch;
        int burst;
        int left;
        left = 0;
        for (int i = 0; i < NUM_CHANNELS; i++)
            left += chan_todo[i].size();
        while (left > 0) begin
            ch    = $urandom_range(0, NUM_CHANNELS - 1);
            burst = $urandom_range(1, 4);
            while (burst > 0 && chan_todo[ch].size() > 0) begin
                beats_to_send.push_back(chan_todo[ch].pop_front());
                burst--;
                left--;
            end
        end
    endtask

    task automatic random_traffic(input int n);
        int built;
        int ch;
        int prev;
        built = 0;
        while (built < n) begin
            ch   = $urandom_range(0, NUM_CHANNELS - 1);
            prev = chan_todo[ch].size();
            build_sequence(ch);
            built += chan_todo[ch].size() - prev;
        end
        release_traffic();
    endtask

    initial begin
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = 1'b0;
        s_tlast   = 1'b0;
        m_tready  = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = CFG_FRAME_MAGIC;
        cfg_wdata = '0;
        exp_magic   = RST_FRAME_MAGIC;
        exp_version = RST_PROTOCOL_VERSION;
        exp_max_len = RST_MAX_PAYLOAD_LEN;
        for (int i = 0; i < NUM_CHANNELS; i++)
            clear_chan(i);
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        random_traffic(100);
        drain();

        set_regs(32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF);
        add_header(15, 32'hFFFF_FFFF, 8'h00, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
        add_beat(15, 1'b0, 8'h00, 1'b1);
        add_beat(15, 1'b1, 8'hA5, 1'b0);
        add_beat(0, 1'b1, 8'h5A, 1'b1);
        release_traffic();
        drain();
        random_traffic(120);
        drain();

        set_regs(32'h0, 32'hFF, 32'h0);
        random_traffic(100);
        drain();

        set_regs($urandom, $urandom_range(0, 255), 32'd8);
        send_idle_pct  = 60;
        recv_stall_pct = 60;
        hold_asked++;
        random_traffic(150);
        drain();

        set_regs($urandom, 32'd1, 32'd5);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_asked++;
        random_traffic(150);
        drain();

        set_regs($urandom, $urandom_range(0, 255), 32'd12);
        send_idle_pct  = 100;
        recv_stall_pct = 100;
        random_traffic(150);
        drain();

        $display("Sent %0d beats over six register settings; checked %0d results.",
                 beats_in, events_out);
        $display("Payload %0d, empty frame %0d, bad header %0d, abort %0d.",
                 ev_seen[0], ev_seen[1], ev_seen[2], ev_seen[3]);
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
